// ===== design/fis_pkg.sv =====
package fis_pkg;

    // Field widths
    localparam int SEC_W      = 32;
    localparam int NSEC_W     = 30;
    localparam int IVL_W      = 48;
    localparam int JIT_W      = 49;
    localparam int FPS_W      = 32;
    localparam int MCOUNT_W   = 32;
    localparam int DEADLINE_W = 32;

    // Stream widths
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 264;
    localparam int OUT_USER_W = 2;

    // Bit positions in the output tuser
    localparam int USER_VALID_BIT = 0;
    localparam int USER_UPD_BIT   = 1;

    // Shared unit accumulator: signed high half, low half
    localparam int ACC_HI_W = 51;
    localparam int ACC_LO_W = 48;
    localparam int ACC_W    = ACC_HI_W + ACC_LO_W;

    // Step counter for the bit-serial operations
    localparam int STEP_W = $clog2(ACC_LO_W);
    localparam logic [STEP_W-1:0] LO_LAST  = STEP_W'(ACC_LO_W - 1);
    localparam logic [STEP_W-1:0] Q32_LAST = STEP_W'(FPS_W - 1);
    localparam int Q32_PAD = ACC_LO_W - FPS_W;

    localparam logic signed [NSEC_W:0] NS_PER_SEC   = 31'sd1000000000;
    localparam logic [DEADLINE_W-1:0]  DEADLINE_RST = 32'd80000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIFF,
        ST_CHECK,
        ST_SAMPLE_DIV,
        ST_FPS_LOAD,
        ST_FPS_MUL,
        ST_FPS_ALIGN,
        ST_FPS_DIV,
        ST_JIT_LOAD,
        ST_JIT_MUL,
        ST_JIT_NEG,
        ST_JIT_DIV,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_LOAD,
        ALU_MUL,
        ALU_DIV,
        ALU_NEG
    } t_alu_op;

    typedef struct packed {
        t_alu_op               op;
        logic [ACC_HI_W-1:0]   opd;
        logic [ACC_HI_W-1:0]   load_hi;
        logic [ACC_LO_W-1:0]   load_lo;
    } t_alu_cmd;

endpackage

// ===== design/fis_alu.sv =====
module fis_alu import fis_pkg::*; (
    input  logic                i_clk,
    input  t_alu_cmd            i_cmd,
    output logic [ACC_HI_W-1:0] o_hi,
    output logic [ACC_LO_W-1:0] o_lo
);

    logic [ACC_HI_W-1:0] r_hi, n_hi;
    logic [ACC_LO_W-1:0] r_lo, n_lo;
    logic [ACC_HI_W:0]   mul_sum;
    logic [ACC_HI_W-1:0] div_sh;
    logic                div_ge;
    logic [ACC_W-1:0]    neg_val;

    // Step datapath: shift-add multiply, restoring divide, negate
    always_comb begin
        mul_sum = {r_hi[ACC_HI_W-1], r_hi}
                + (r_lo[0] ? {i_cmd.opd[ACC_HI_W-1], i_cmd.opd} : '0);
        div_sh  = {r_hi[ACC_HI_W-2:0], r_lo[ACC_LO_W-1]};
        div_ge  = (div_sh >= i_cmd.opd);
        neg_val = ~{r_hi, r_lo} + ACC_W'(1);

        n_hi = r_hi;
        n_lo = r_lo;
        case (i_cmd.op)
            ALU_LOAD: begin
                n_hi = i_cmd.load_hi;
                n_lo = i_cmd.load_lo;
            end
            ALU_MUL: begin
                // add multiplicand on the low bit, then shift right arithmetically
                n_hi = mul_sum[ACC_HI_W:1];
                n_lo = {mul_sum[0], r_lo[ACC_LO_W-1:1]};
            end
            ALU_DIV: begin
                // remainder in the high half, quotient shifts into the low half
                n_hi = div_ge ? (div_sh - i_cmd.opd) : div_sh;
                n_lo = {r_lo[ACC_LO_W-2:0], div_ge};
            end
            ALU_NEG: begin
                n_hi = neg_val[ACC_W-1:ACC_LO_W];
                n_lo = neg_val[ACC_LO_W-1:0];
            end
            default: begin
                n_hi = r_hi;
                n_lo = r_lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;

endmodule

// ===== design/frame_interval_statistics_top.sv =====
// Frame interval statistics. Each input transaction carries one frame's start and end
// timestamps (seconds, nanoseconds); each output transaction returns the interval, the
// jitter against the deadline register and the running means of frame rate (unsigned
// Q16.16 by default) and jitter, the worst interval and the number of measured intervals.
// The first frame after reset is only timed, and a frame whose end precedes its start
// leaves the statistics untouched. Only a frame that updates them uses the one shared
// shift-add/restore unit, which runs the rate reciprocal (32 steps), the two mean
// products (48 steps each) and the two mean divisions (32 and 48 steps) one bit per
// cycle; the reciprocal is skipped when the rate sample saturates. The block accepts a
// new frame while the previous result still waits in the output register. Deadline
// writes are taken at any time but belong between frames.
module frame_interval_statistics_top import fis_pkg::*; #(
    parameter int COUNT_BITS    = 32,
    parameter int FPS_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: deadline_ns
    input  logic                   i_cfg_we,
    input  logic [DEADLINE_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata from bit 0: start_sec[31:0], start_nsec[29:0], end_sec[31:0],
    // end_nsec[29:0], zero pad[3:0]
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata from bit 0: interval_ns[47:0], frame_jitter_ns[48:0], mean_fps[31:0],
    // mean_jitter_ns[48:0], worst_interval_ns[47:0], measured_count[31:0],
    // zero pad[5:0]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    // tuser from bit 0: interval_valid, stats_updated
    output logic [OUT_USER_W-1:0]  o_m_axis_tuser
);

    localparam logic [63:0] FPS_NUM = 64'd1000000000 << FPS_FRAC_BITS;
    localparam logic [ACC_HI_W-1:0] NUM_HI = ACC_HI_W'(FPS_NUM[63:32]);
    localparam logic [FPS_W-1:0] NUM_LO = FPS_NUM[31:0];

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    logic signed [SEC_W:0]  r_dsec;
    logic [NSEC_W:0]        r_dns;
    logic signed [63:0]     r_prod;
    logic                   r_valid;
    logic [IVL_W-1:0]       r_interval;
    logic [JIT_W-1:0]       r_inst;
    logic                   r_upd;
    logic                   r_sat;
    logic                   r_neg;

    logic [DEADLINE_W-1:0]  r_deadline;
    logic                   r_first;
    logic [COUNT_BITS-1:0]  r_count;
    logic [FPS_W-1:0]       r_fps;
    logic [JIT_W-1:0]       r_jit;
    logic [IVL_W-1:0]       r_max;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic [OUT_USER_W-1:0]  r_out_user;

    t_alu_cmd               alu_cmd;
    logic [ACC_HI_W-1:0]    alu_hi;
    logic [ACC_LO_W-1:0]    alu_lo;

    logic                   s_acc;
    logic                   fin_go;
    logic [63:0]            diff;
    logic                   diff_valid;
    logic [IVL_W-1:0]       diff_interval;
    logic [JIT_W-1:0]       diff_inst;
    logic [ACC_LO_W-1:0]    n_ext;
    logic [ACC_HI_W-1:0]    div_n1;
    logic [ACC_HI_W-1:0]    interval_ext;
    logic [JIT_W-1:0]       jit_mag;
    logic [JIT_W-1:0]       jit_res;
    logic [JIT_W-1:0]       fin_jit;
    logic [IVL_W-1:0]       fin_max;
    logic [COUNT_BITS-1:0]  fin_count;
    logic [IVL_W-1:0]       cnt_ext;
    logic [MCOUNT_W-1:0]    meas;

    fis_alu u_alu (
        .i_clk (i_clk),
        .i_cmd (alu_cmd),
        .o_hi  (alu_hi),
        .o_lo  (alu_lo)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign fin_go = (r_state == ST_FINISH) && (!r_out_valid || i_m_axis_tready);

    // Interval from the scaled seconds difference plus nanosecond difference
    always_comb begin
        diff          = r_prod + {{(64 - NSEC_W - 1){r_dns[NSEC_W]}}, r_dns};
        diff_valid    = !diff[63];
        diff_interval = '0;
        diff_inst     = '0;
        if (diff_valid) begin
            diff_interval = (|diff[62:IVL_W]) ? '1 : diff[IVL_W-1:0];
            diff_inst     = {{(JIT_W - DEADLINE_W){1'b0}}, r_deadline}
                          - {1'b0, diff_interval};
        end
    end

    // Operands and committed values
    always_comb begin
        n_ext        = ACC_LO_W'(r_count);
        div_n1       = ACC_HI_W'(r_count) + ACC_HI_W'(1);
        interval_ext = ACC_HI_W'(r_interval);
        jit_mag      = {1'b0, alu_lo};
        jit_res      = r_neg ? (~jit_mag + JIT_W'(1)) : jit_mag;
        fin_jit      = r_upd ? jit_res : r_jit;
        fin_max      = (r_upd && (r_interval > r_max)) ? r_interval : r_max;
        fin_count    = (r_upd && (r_count != '1)) ? (r_count + COUNT_BITS'(1)) : r_count;
        cnt_ext      = IVL_W'(fin_count);
        meas         = (|cnt_ext[IVL_W-1:MCOUNT_W]) ? '1 : cnt_ext[MCOUNT_W-1:0];
    end

    // Sequencer: next state, step count and shared unit command
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        alu_cmd = '{op: ALU_HOLD, opd: '0, load_hi: '0, load_lo: '0};
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!(r_first && r_valid)) begin
                    n_state = ST_FINISH;
                end else if (NUM_HI >= interval_ext) begin
                    n_state = ST_FPS_LOAD;
                end else begin
                    alu_cmd.op      = ALU_LOAD;
                    alu_cmd.load_hi = NUM_HI;
                    alu_cmd.load_lo = {NUM_LO, {Q32_PAD{1'b0}}};
                    n_state         = ST_SAMPLE_DIV;
                end
            end
            ST_SAMPLE_DIV: begin
                alu_cmd.op  = ALU_DIV;
                alu_cmd.opd = interval_ext;
                n_step      = r_step + STEP_W'(1);
                if (r_step == Q32_LAST) begin
                    n_step  = '0;
                    n_state = ST_FPS_LOAD;
                end
            end
            ST_FPS_LOAD: begin
                alu_cmd.op      = ALU_LOAD;
                alu_cmd.load_hi = r_sat ? ACC_HI_W'({FPS_W{1'b1}})
                                        : ACC_HI_W'(alu_lo[FPS_W-1:0]);
                alu_cmd.load_lo = n_ext;
                n_state         = ST_FPS_MUL;
            end
            ST_FPS_MUL: begin
                alu_cmd.op  = ALU_MUL;
                alu_cmd.opd = ACC_HI_W'(r_fps);
                n_step      = r_step + STEP_W'(1);
                if (r_step == LO_LAST) begin
                    n_step  = '0;
                    n_state = ST_FPS_ALIGN;
                end
            end
            ST_FPS_ALIGN: begin
                // split the sum at bit 32: upper part preloads the remainder
                alu_cmd.op      = ALU_LOAD;
                alu_cmd.load_hi = {alu_hi[ACC_HI_W-Q32_PAD-1:0], alu_lo[ACC_LO_W-1:FPS_W]};
                alu_cmd.load_lo = {alu_lo[FPS_W-1:0], {Q32_PAD{1'b0}}};
                n_state         = ST_FPS_DIV;
            end
            ST_FPS_DIV: begin
                alu_cmd.op  = ALU_DIV;
                alu_cmd.opd = div_n1;
                n_step      = r_step + STEP_W'(1);
                if (r_step == Q32_LAST) begin
                    n_step  = '0;
                    n_state = ST_JIT_LOAD;
                end
            end
            ST_JIT_LOAD: begin
                alu_cmd.op      = ALU_LOAD;
                alu_cmd.load_hi = {{(ACC_HI_W - JIT_W){r_inst[JIT_W-1]}}, r_inst};
                alu_cmd.load_lo = n_ext;
                n_state         = ST_JIT_MUL;
            end
            ST_JIT_MUL: begin
                alu_cmd.op  = ALU_MUL;
                alu_cmd.opd = {{(ACC_HI_W - JIT_W){r_jit[JIT_W-1]}}, r_jit};
                n_step      = r_step + STEP_W'(1);
                if (r_step == LO_LAST) begin
                    n_step  = '0;
                    n_state = ST_JIT_NEG;
                end
            end
            ST_JIT_NEG: begin
                // divide the magnitude, restore the sign at the end
                if (alu_hi[ACC_HI_W-1]) begin
                    alu_cmd.op = ALU_NEG;
                end
                n_state = ST_JIT_DIV;
            end
            ST_JIT_DIV: begin
                alu_cmd.op  = ALU_DIV;
                alu_cmd.opd = div_n1;
                n_step      = r_step + STEP_W'(1);
                if (r_step == LO_LAST) begin
                    n_step  = '0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_deadline  <= DEADLINE_RST;
            r_first     <= 1'b0;
            r_count     <= '0;
            r_fps       <= '0;
            r_jit       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                r_deadline <= i_cfg_wdata;
            end
            if (r_state == ST_JIT_LOAD) begin
                r_fps <= alu_lo[FPS_W-1:0];
            end
            if (fin_go) begin
                r_first <= 1'b1;
                r_jit   <= fin_jit;
                r_max   <= fin_max;
                r_count <= fin_count;
            end
            // hold the result until the output transaction completes
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-frame working registers and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    r_dsec <= {1'b0, i_s_axis_tdata[93:62]} - {1'b0, i_s_axis_tdata[31:0]};
                    r_dns  <= {1'b0, i_s_axis_tdata[123:94]} - {1'b0, i_s_axis_tdata[61:32]};
                end
            end
            ST_MULT: begin
                r_prod <= r_dsec * NS_PER_SEC;
            end
            ST_DIFF: begin
                r_valid    <= diff_valid;
                r_interval <= diff_interval;
                r_inst     <= diff_inst;
            end
            ST_CHECK: begin
                r_upd <= r_first && r_valid;
                r_sat <= (NUM_HI >= interval_ext);
            end
            ST_JIT_NEG: begin
                r_neg <= alu_hi[ACC_HI_W-1];
            end
            ST_FINISH: begin
                if (fin_go) begin
                    r_out_data <= {6'b0, meas, fin_max, fin_jit, r_fps, r_inst, r_interval};
                    r_out_user <= {r_upd, r_valid};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Busy after every accepted frame
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input accepted while a frame is in progress");

    // Divider remainder stays below the divisor, preloads included
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAMPLE_DIV || r_state == ST_FPS_DIV || r_state == ST_JIT_DIV)
        |-> (alu_hi < alu_cmd.opd))
        else $error("divider remainder not below divisor");

    // Count advances by one per update, or stays saturated
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_upd)
        |=> ((r_count == COUNT_BITS'($past(r_count) + COUNT_BITS'(1))) || (r_count == '1)))
        else $error("measured count did not advance");

    // First frame never updates the statistics
    a_first_only_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && !r_first) |-> !r_upd)
        else $error("first frame updated the statistics");

    // Worst interval covers every measured interval
    a_worst_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[USER_UPD_BIT])
        |-> (o_m_axis_tdata[225:178] >= o_m_axis_tdata[47:0]))
        else $error("worst interval below a measured interval");

endmodule

// ===== tb/sv/frame_interval_statistics_checker.sv =====
// Watches both streams and the deadline port of the frame interval statistics block,
// predicts each result from its own copy of the running statistics and compares it
// field by field with what the block returns.
module frame_interval_statistics_checker import fis_pkg::*; #(
    parameter int COUNT_BITS    = 32,
    parameter int FPS_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DEADLINE_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [OUT_USER_W-1:0] i_m_tuser,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] SAT48     = (64'd1 << IVL_W) - 64'd1;
    localparam logic [63:0] SAT32     = 64'hFFFF_FFFF;
    localparam logic [63:0] NS_SEC    = 64'd1000000000;

    typedef struct packed {
        logic                 valid;
        logic [IVL_W-1:0]     interval;
        logic [JIT_W-1:0]     frame_jitter;
        logic                 updated;
        logic [FPS_W-1:0]     mean_fps;
        logic [JIT_W-1:0]     mean_jitter;
        logic [IVL_W-1:0]     worst;
        logic [MCOUNT_W-1:0]  count;
    } t_frame_stats;

    // Shadow of the block's configuration and statistics
    logic [DEADLINE_W-1:0] deadline;
    logic                  seen_first;
    logic [63:0]           measured;
    logic [FPS_W-1:0]      fps_avg;
    logic [JIT_W-1:0]      jitter_avg;
    logic [IVL_W-1:0]      worst_seen;

    t_frame_stats expected_stats_q[$];
    int           mismatch_count = 0;
    int           result_no = 0;

    assign o_errors = mismatch_count;

    // Advance the shadow statistics by one frame and return its expected result
    task automatic predict_frame_stats(input logic [IN_DATA_W-1:0] tdata,
                                       output t_frame_stats res);
        logic [63:0]         t0, t1, ivl, sample;
        logic [JIT_W-1:0]    inst;
        logic [127:0]        fps_acc, fps_q;
        logic signed [127:0] jit_acc, jit_q, n_s, d_s, jm_s, inst_s;
        t0 = 64'(tdata[31:0]) * NS_SEC + 64'(tdata[61:32]);
        t1 = 64'(tdata[93:62]) * NS_SEC + 64'(tdata[123:94]);
        res = '0;
        res.valid = (t1 >= t0);
        ivl = 64'd0;
        inst = '0;
        if (res.valid) begin
            ivl = t1 - t0;
            if (ivl > SAT48) ivl = SAT48;
            inst = JIT_W'(deadline) - JIT_W'(ivl);
        end
        if (!seen_first) begin
            seen_first = 1'b1;
        end else if (res.valid) begin
            res.updated = 1'b1;
            // rate sample: reciprocal of the interval, saturated
            if (ivl == 64'd0) begin
                sample = SAT32;
            end else begin
                sample = 64'((128'd1000000000 << FPS_FRAC_BITS) / 128'(ivl));
                if (((128'd1000000000 << FPS_FRAC_BITS) / 128'(ivl)) > 128'(SAT32))
                    sample = SAT32;
            end
            fps_acc = 128'(fps_avg) * 128'(measured) + 128'(sample);
            fps_q = fps_acc / (128'(measured) + 128'd1);
            fps_avg = fps_q[FPS_W-1:0];
            // jitter mean: signed, truncated toward zero
            n_s = $signed(128'(measured));
            d_s = $signed(128'(measured) + 128'd1);
            jm_s = {{(128-JIT_W){jitter_avg[JIT_W-1]}}, jitter_avg};
            inst_s = {{(128-JIT_W){inst[JIT_W-1]}}, inst};
            jit_acc = jm_s * n_s + inst_s;
            jit_q = jit_acc / d_s;
            jitter_avg = jit_q[JIT_W-1:0];
            if (ivl[IVL_W-1:0] > worst_seen) worst_seen = ivl[IVL_W-1:0];
            if (measured < COUNT_MAX) measured = measured + 64'd1;
        end
        res.interval     = ivl[IVL_W-1:0];
        res.frame_jitter = inst;
        res.mean_fps     = fps_avg;
        res.mean_jitter  = jitter_avg;
        res.worst        = worst_seen;
        res.count        = (measured > SAT32) ? MCOUNT_W'(SAT32) : measured[MCOUNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            if (mismatch_count < 10)
                $display("Result %0d, %s: expected 0x%0h, got 0x%0h",
                         result_no, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_stats exp_r;
        t_frame_stats act_r;
        if (!i_rst_n) begin
            deadline   = DEADLINE_RST;
            seen_first = 1'b0;
            measured   = 64'd0;
            fps_avg    = '0;
            jitter_avg = '0;
            worst_seen = '0;
            expected_stats_q.delete();
        end else begin
            // compare a returned transaction with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                act_r.valid        = i_m_tuser[USER_VALID_BIT];
                act_r.updated      = i_m_tuser[USER_UPD_BIT];
                act_r.interval     = i_m_tdata[47:0];
                act_r.frame_jitter = i_m_tdata[96:48];
                act_r.mean_fps     = i_m_tdata[128:97];
                act_r.mean_jitter  = i_m_tdata[177:129];
                act_r.worst        = i_m_tdata[225:178];
                act_r.count        = i_m_tdata[257:226];
                if (expected_stats_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Result %0d arrived with no frame outstanding", result_no);
                    mismatch_count++;
                end else begin
                    exp_r = expected_stats_q.pop_front();
                    check_field("interval_valid", 64'(exp_r.valid), 64'(act_r.valid));
                    check_field("interval_ns", 64'(exp_r.interval), 64'(act_r.interval));
                    check_field("frame_jitter_ns", 64'(exp_r.frame_jitter),
                                64'(act_r.frame_jitter));
                    check_field("stats_updated", 64'(exp_r.updated), 64'(act_r.updated));
                    check_field("mean_fps", 64'(exp_r.mean_fps), 64'(act_r.mean_fps));
                    check_field("mean_jitter_ns", 64'(exp_r.mean_jitter),
                                64'(act_r.mean_jitter));
                    check_field("worst_interval_ns", 64'(exp_r.worst), 64'(act_r.worst));
                    check_field("measured_count", 64'(exp_r.count), 64'(act_r.count));
                end
                result_no++;
            end
            if (i_cfg_we) deadline = i_cfg_wdata;
            // predict the result of an accepted frame
            if (i_s_tvalid && i_s_tready) begin
                predict_frame_stats(i_s_tdata, exp_r);
                expected_stats_q.push_back(exp_r);
            end
        end
        o_pending <= expected_stats_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench import fis_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT     = 20000;
    localparam int FRAMES_PER_PASS = 92;
    localparam int NUM_PASSES      = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [DEADLINE_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int frames_sent = 0;
    int deadline_writes = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    frame_interval_statistics_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    frame_interval_statistics_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tuser   (o_m_axis_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Present one frame, idling first as the current pattern asks, and hold until taken
    task automatic send_frame(input logic [31:0] s_sec, input logic [29:0] s_nsec,
                              input logic [31:0] e_sec, input logic [29:0] e_nsec);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, e_nsec, e_sec, s_nsec, s_sec};
        do @(posedge i_clk); while (!o_s_axis_tready);
        frames_sent++;
    endtask

    // Mostly well-formed frames with random timing, plus inverted, noisy and
    // out-of-range nanosecond frames
    task automatic send_random_frame();
        logic [63:0] t0, t1, ivl;
        logic [31:0] s0, s1;
        logic [29:0] n0, n1;
        int          mode, cls;
        mode = $urandom_range(99);
        cls  = $urandom_range(9);
        s0 = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(100000));
        n0 = 30'($urandom_range(999999999));
        case (cls)
            6:       ivl = 64'($urandom_range(20000));
            7:       ivl = {$urandom, $urandom} >> $urandom_range(63);
            8:       ivl = 64'($urandom_range(1));
            9:       ivl = 64'($urandom_range(1000000000, 16666000));
            default: ivl = 64'($urandom_range(100000000, 5000000));
        endcase
        t0 = 64'(s0) * 64'd1000000000 + 64'(n0);
        t1 = t0 + ivl;
        if (t1 < t0 || (t1 / 64'd1000000000) > 64'hFFFF_FFFF) begin
            s1 = 32'hFFFF_FFFF;
            n1 = 30'($urandom_range(999999999));
        end else begin
            s1 = 32'(t1 / 64'd1000000000);
            n1 = 30'(t1 % 64'd1000000000);
        end
        if (mode < 70) begin
            send_frame(s0, n0, s1, n1);
        end else if (mode < 80) begin
            send_frame(s1, n1, s0, n0);
        end else if (mode < 90) begin
            send_frame($urandom, 30'($urandom), $urandom, 30'($urandom));
        end else begin
            send_frame(s0, 30'($urandom_range(30'h3FFF_FFFF, 1000000000)),
                       s0 + 32'($urandom_range(2)),
                       30'($urandom_range(30'h3FFF_FFFF, 1000000000)));
        end
    endtask

    // Wait until every result is back, let the block settle, then write the deadline
    task automatic write_deadline(input logic [DEADLINE_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        deadline_writes++;
    endtask

    initial begin
        logic [DEADLINE_W-1:0] dl;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first frame only timed, then zero, inverted, borrow, saturation
        send_frame(32'd0, 30'd0, 32'd0, 30'd33333333);
        send_frame(32'd1, 30'd0, 32'd1, 30'd33333333);
        send_frame(32'd2, 30'd500, 32'd2, 30'd500);
        send_frame(32'd3, 30'd1, 32'd3, 30'd0);
        send_frame(32'd5, 30'd999999999, 32'd6, 30'd0);
        send_frame(32'd10, 30'h3FFF_FFFF, 32'd11, 30'h3FFF_FFFF);
        send_frame(32'd0, 30'd0, 32'hFFFF_FFFF, 30'd999999999);
        send_frame(32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd0, 30'd0);
        send_frame(32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_frame(32'd0, 30'd0, 32'd281474, 30'd976710655);
        send_frame(32'd0, 30'd0, 32'd281474, 30'd976710656);
        send_frame(32'd7, 30'd0, 32'd7, 30'd15258);
        send_frame(32'd7, 30'd0, 32'd7, 30'd15259);
        send_frame(32'hFFFF_FFF0, 30'd0, 32'hFFFF_FFFF, 30'd999999999);
        send_frame(32'd20, 30'd900000000, 32'd21, 30'd10000000);
        send_frame(32'd30, 30'd0, 32'd30, 30'd80000000);
        send_frame(32'd40, 30'd0, 32'd40, 30'd16666667);
        send_frame(32'd50, 30'd999999999, 32'd49, 30'd999999999);

        // Random passes, each with its own deadline and one of four idling patterns
        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            case (pass)
                0:       dl = 32'd0;
                1:       dl = 32'hFFFF_FFFF;
                2:       dl = 32'd33333333;
                4:       dl = 32'd16666667;
                5:       dl = 32'd1;
                7:       dl = DEADLINE_RST;
                default: dl = $urandom;
            endcase
            write_deadline(dl);
            case (pass % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            repeat (FRAMES_PER_PASS) send_random_frame();
        end

        // Drain and let the block go quiet
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (64) @(posedge i_clk);

        $display("Sent %0d frames over %0d deadline settings with four idling patterns",
                 frames_sent, deadline_writes);
        $display("Directed cases: borrow, zero, inverted, saturated and out-of-range frames");
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fis_pkg.sv
design/fis_alu.sv
design/frame_interval_statistics_top.sv
tb/sv/frame_interval_statistics_checker.sv
tb/sv/testbench.sv
